// ----- src/iflog_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iflog_pkg
// Shared widths and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package iflog_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned HALF_W  = WORD_W / 2;
    localparam int unsigned PROD_W  = WORD_W + HALF_W;
    localparam int unsigned COUNT_W = 6;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture operand and base
        logic start;   // first compare of base against operand
        logic mul;     // form partial products of power * base
        logic step;    // combine products, compare, advance count
        logic emit;    // move count into the output register
    } iflog_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic start_go;  // base at least two, fits a half word, and base <= operand
        logic step_go;   // next power still <= operand
    } iflog_stat_t;

endpackage

// ----- src/iflog_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iflog_dp
// Datapath: operand, base, running power, split multiplier and the count.
// ----------------------------------------------------------------------------
module iflog_dp import iflog_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  iflog_cmd_t           cmd,
    output iflog_stat_t          stat,
    input  logic [WORD_W-1:0]    operand_value,
    input  logic [WORD_W-1:0]    log_base,
    output logic [COUNT_W-1:0]   log_result
);

    localparam logic [WORD_W-1:0] VAL_MASK = (DATA_WIDTH >= WORD_W) ? {WORD_W{1'b1}} :
        ((WORD_W'(1) << (DATA_WIDTH % WORD_W)) - WORD_W'(1));

    logic [WORD_W-1:0]  v_reg;
    logic [WORD_W-1:0]  b_reg;
    logic [WORD_W-1:0]  p_reg;
    logic [WORD_W-1:0]  prod_lo_reg;
    logic [WORD_W-1:0]  prod_hi_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] result_reg;

    logic               b_lt2;
    logic               b_le_v;
    logic [PROD_W-1:0]  total;

    assign b_lt2  = (b_reg < WORD_W'(2));
    assign b_le_v = (b_reg <= v_reg);
    assign total  = {prod_hi_reg, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, prod_lo_reg};

    // Bases of a half word or wider square past any operand: at most one step.
    assign stat.start_go = !b_lt2 && (b_reg[WORD_W-1:HALF_W] == '0) && b_le_v;
    assign stat.step_go  = (total[PROD_W-1:WORD_W] == '0) && (total[WORD_W-1:0] <= v_reg);

    assign log_result = result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg <= operand_value & VAL_MASK;
            b_reg <= log_base & VAL_MASK;
        end
        if (cmd.start)
        begin
            p_reg     <= b_reg;
            count_reg <= {{(COUNT_W-1){1'b0}}, (!b_lt2 && b_le_v)};
        end
        if (cmd.mul)
        begin
            prod_lo_reg <= p_reg[HALF_W-1:0] * b_reg[HALF_W-1:0];
            prod_hi_reg <= p_reg[WORD_W-1:HALF_W] * b_reg[HALF_W-1:0];
        end
        if (cmd.step && stat.step_go)
        begin
            p_reg     <= total[WORD_W-1:0];
            count_reg <= count_reg + COUNT_W'(1);
        end
        if (cmd.emit)
        begin
            result_reg <= count_reg;
        end
    end

    // The largest reachable count is that of base two on an all-ones operand.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && stat.step_go) |-> (count_reg != {COUNT_W{1'b1}}))
        else $error("iflog_dp: count would wrap");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (result_reg == $past(count_reg)))
        else $error("iflog_dp: result not taken from count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && stat.step_go) |=> (p_reg <= v_reg))
        else $error("iflog_dp: running power exceeded operand");

endmodule

// ----- src/iflog_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iflog_ctrl
// Controller: sequences load, power steps and hand-off to the output register.
// ----------------------------------------------------------------------------
module iflog_ctrl import iflog_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output iflog_cmd_t  cmd,
    input  iflog_stat_t stat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                state_next = stat.start_go ? S_MUL : S_DONE;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.step   = 1'b1;
                state_next = stat.step_go ? S_MUL : S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_START))
        else $error("iflog_ctrl: accepted word did not start");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("iflog_ctrl: result raised outside done");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> ($past(state_reg) == S_START || $past(state_reg) == S_CMP))
        else $error("iflog_ctrl: multiply entered from wrong state");

endmodule

// ----- src/integer_floor_log_any_base.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_floor_log_any_base
// Floor of the logarithm of a 64-bit unsigned operand in any base of two or up.
// ----------------------------------------------------------------------------
// One word at a time. The block raises the base to successive powers and counts
// how many stay at or below the operand. Each power step first forms two
// half-word by half-word products, then combines them and compares. A base of
// 2^32 or more, or below two, skips the power steps and goes from the first
// compare straight to the result. A new word is accepted while the previous
// result waits in the output register. Bases zero and one give 0.
module integer_floor_log_any_base import iflog_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [WORD_W-1:0]   operand_value,
    input  logic [WORD_W-1:0]   log_base,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COUNT_W-1:0]  log_result
);

    iflog_cmd_t  cmd;
    iflog_stat_t stat;

    iflog_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    iflog_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operand_value (operand_value),
        .log_base      (log_base),
        .log_result    (log_result)
    );

endmodule

// ----- test/integer_floor_log_any_base_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_floor_log_any_base_tb
// Self-checking bench for the floor-logarithm block in an arbitrary base.
// ----------------------------------------------------------------------------
// A short table of directed words covers zero operands, bases zero, one, two
// and all ones, exact powers and their neighbours. Random words follow, most
// of them placed on or next to a power of the base. Each result is checked
// against a typed-in value or a predictor kept here. Both ports idle at
// random in two of three phases; one long receiver hold-off stalls the input.
// ----------------------------------------------------------------------------
module integer_floor_log_any_base_tb import iflog_pkg::*;;

    localparam int          HALF_PERIOD = 10;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          PHASE_WORDS = 334;
    localparam int          TAIL_CYCLES = 140;
    localparam int          HOLD_CYCLES = 300;
    localparam int          COMPUTE     = -1;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] POW_3_40    = 64'd12157665459056928801;

    typedef struct packed {
        logic [63:0] operand;
        logic [63:0] base;
        int          pinned;   // typed-in result, or COMPUTE
    } probe_t;

    localparam int N_PROBES = 22;
    localparam probe_t PROBES [N_PROBES] = '{
        '{64'd0,            64'd2,            0},
        '{64'd0,            64'd3,            0},
        '{64'd1,            64'd2,            0},
        '{64'd2,            64'd2,            1},
        '{ALL_ONES,         64'd2,            63},
        '{64'h8000_0000_0000_0000, 64'd2,     63},
        '{ALL_ONES,         64'd0,            0},
        '{ALL_ONES,         64'd1,            0},
        '{64'd5,            64'd0,            0},
        '{64'd0,            64'd0,            0},
        '{64'd0,            ALL_ONES,         0},
        '{ALL_ONES,         ALL_ONES,         1},
        '{ALL_ONES - 1,     ALL_ONES,         0},
        '{64'd9,            64'd10,           0},
        '{64'd10,           64'd10,           1},
        '{64'd100,          64'd10,           2},
        '{64'd99,           64'd10,           COMPUTE},
        '{ALL_ONES,         64'd3,            COMPUTE},
        '{POW_3_40,         64'd3,            COMPUTE},
        '{POW_3_40 - 1,     64'd3,            COMPUTE},
        '{ALL_ONES,         64'hFFFF_FFFF,    COMPUTE},
        '{ALL_ONES,         64'h1_0000_0001,  COMPUTE}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [WORD_W-1:0]   operand_value;
    logic [WORD_W-1:0]   log_base;
    logic                out_valid;
    logic                out_ready;
    logic [COUNT_W-1:0]  log_result;

    logic [COUNT_W-1:0]  offered_logs [$];   // words on the input, not yet taken
    logic [COUNT_W-1:0]  due_logs [$];       // words taken, result still owed
    int unsigned         src_idle_pct;
    int unsigned         sink_idle_pct;
    int unsigned         hold_asks;
    int unsigned         hold_done;
    int unsigned         hold_left;
    int unsigned         faults;
    int unsigned         words_sent;
    int unsigned         results_seen;
    int unsigned         base_two_words;
    int unsigned         odd_base_words;
    int unsigned         cycle_count;

    integer_floor_log_any_base uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operand_value (operand_value),
        .log_base      (log_base),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .log_result    (log_result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    // count whole divisions by the base until the operand drops below it
    function automatic logic [COUNT_W-1:0] floor_log_of(logic [63:0] v, logic [63:0] b);
        int unsigned n;
        n = 0;
        if (b < 64'd2)
            return '0;
        if (b == 64'd2)
        begin
            while (v > 64'd1)
            begin
                v = v >> 1;
                n++;
            end
        end
        else
        begin
            while (v >= b)
            begin
                v = v / b;
                n++;
            end
        end
        return n[COUNT_W-1:0];
    endfunction

    task automatic offer_word(input logic [63:0] v, input logic [63:0] b, input int pinned);
        int unsigned gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (pinned == COMPUTE)
            offered_logs.push_back(floor_log_of(v, b));
        else
            offered_logs.push_back(pinned[COUNT_W-1:0]);
        if (b == 64'd2)
            base_two_words++;
        if (b < 64'd2)
            odd_base_words++;
        words_sent++;
        in_valid      <= 1'b1;
        operand_value <= v;
        log_base      <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_asks != hold_done)
        begin
            hold_done = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // scoreboard: move taken words to the owed queue, check each result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                due_logs.push_back(offered_logs.pop_front());
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (due_logs.size() == 0)
                begin
                    $error("log_result: no word outstanding, got %0d", log_result);
                    faults++;
                end
                else if (log_result !== due_logs[0])
                begin
                    $error("log_result: expected %0d, actual %0d", due_logs[0], log_result);
                    faults++;
                    void'(due_logs.pop_front());
                end
                else
                    void'(due_logs.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results owed", cycle_count,
                     due_logs.size());
            $display("integer_floor_log_any_base_tb failed");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] v;
        logic [63:0] b;
        logic [63:0] p;
        int          k;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operand_value  = '0;
        log_base       = '0;
        out_ready      = 1'b0;
        src_idle_pct   = 22;
        sink_idle_pct  = 61;
        hold_asks      = 0;
        hold_done      = 0;
        hold_left      = 0;
        faults         = 0;
        words_sent     = 0;
        results_seen   = 0;
        base_two_words = 0;
        odd_base_words = 0;
        cycle_count    = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_PROBES; i++)
            offer_word(PROBES[i].operand, PROBES[i].base, PROBES[i].pinned);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 22;
                    sink_idle_pct = 61;
                end
                1:
                begin
                    src_idle_pct  = 61;
                    sink_idle_pct = 22;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                // back the block up while the sender keeps offering
                if (phase == 2 && i == 20)
                    hold_asks++;
                case ($urandom_range(9))
                    0:       b = 64'd2;
                    1, 2, 3: b = $urandom_range(16, 3);
                    4, 5:    b = $urandom_range(65535, 17);
                    6:       b = {32'd0, $urandom} | 64'd2;
                    7:       b = {$urandom, $urandom};
                    8:       b = $urandom_range(1, 0);
                    default: b = 64'd1 << $urandom_range(63, 1);
                endcase
                if (b >= 64'd2 && $urandom_range(2) != 0)
                begin
                    // land on a power of the base, or one either side of it
                    p = 64'd1;
                    k = $urandom_range(63, 1);
                    while (k > 0 && p <= ALL_ONES / b)
                    begin
                        p = p * b;
                        k--;
                    end
                    v = p + $urandom_range(2) - 1;
                end
                else
                    v = {$urandom, $urandom} >> $urandom_range(63);
                offer_word(v, b, COMPUTE);
            end
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (due_logs.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d words sent, %0d results checked, %0d mismatches", words_sent,
                 results_seen, faults);
        $display("%0d words in base two, %0d with base below two, one long output stall",
                 base_two_words, odd_base_words);
        if (faults == 0)
            $display("integer_floor_log_any_base_tb passed");
        else
            $display("integer_floor_log_any_base_tb failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/iflog_pkg.sv
src/iflog_dp.sv
src/iflog_ctrl.sv
src/integer_floor_log_any_base.sv
test/integer_floor_log_any_base_tb.sv
